>>> rtl/outlier_rejecting_rms_current_top_defines.svh
// Assertion macros shared by the checker.
`ifndef OUTLIER_REJECTING_RMS_CURRENT_TOP_DEFINES_SVH
`define OUTLIER_REJECTING_RMS_CURRENT_TOP_DEFINES_SVH

// Same-cycle implication
`define ORMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ORMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/orms_pkg.sv
package orms_pkg;

  localparam int SAMPLE_W        = 12;
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int KEPT_W          = 11;
  localparam int CURRENT_W       = 32;
  localparam int OFFSET_W        = 19;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam int SUM_W   = 25;
  localparam int SQ_W    = 37;
  localparam int NQ_W    = 52;
  localparam int VAR_W   = 54;
  localparam int DM_W    = 25;
  localparam int AD_W    = 20;
  localparam int SUMSQ_W = 52;
  localparam int RAW_W   = 58;
  localparam int MAG_W   = 59;
  localparam int PROD_W  = 80;

  localparam logic [31:0] RECIP_M    = 32'd2577609677;
  localparam int          RECIP_SH   = 44;
  localparam logic [30:0] VOLT_BIAS  = 31'd3412;
  localparam logic [CFG_DATA_W-1:0] BURDEN_RST = 32'd65536;
  localparam logic [CFG_DATA_W-1:0] TURNS_RST  = 32'd65536;
  localparam logic [CFG_DATA_W-1:0] GAIN_RST   = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_VOLTAGE    = 3'd0,
    REG_BURDEN_RESISTANCE = 3'd1,
    REG_TURNS_RATIO       = 3'd2,
    REG_CORRECTION_GAIN   = 3'd3,
    REG_CORRECTION_OFFSET = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> rtl/orms_if.sv
interface orms_in_if;
  logic                          valid;
  logic                          ready;
  logic [orms_pkg::SAMPLE_W-1:0] adc_sample;
  logic                          last_sample;
  modport source (output valid, adc_sample, last_sample, input ready);
  modport sink (input valid, adc_sample, last_sample, output ready);
endinterface

interface orms_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [orms_pkg::CURRENT_W-1:0] current_value;
  logic [orms_pkg::KEPT_W-1:0]           kept_count;
  modport source (output valid, current_value, kept_count, input ready);
  modport sink (input valid, current_value, kept_count, output ready);
endinterface

interface orms_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [orms_pkg::CFG_IDX_W-1:0]  index;
  logic [orms_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/orms_div.sv
module orms_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            dividend,
  input  logic [31:0]            divisor,
  output orms_pkg::unit_stat_t   stat,
  output logic [63:0]            quotient
);

  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem[31:0], quotient[63]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= 7'd64;
      end else if (stat.busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (stat.busy) begin
      rem      <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      quotient <= {quotient[62:0], fits};
    end
  end

endmodule

>>> rtl/orms_sqrt.sv
module orms_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          radicand,
  output orms_pkg::unit_stat_t stat,
  output logic [31:0]          root
);

  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitw;
  logic [63:0] trial;

  assign trial = r + bitw;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && bitw == 64'd1) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      r    <= '0;
      bitw <= 64'd1 << 62;
    end else if (stat.busy) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + bitw;
      end else begin
        r <= r >> 1;
      end
      bitw <= bitw >> 2;
    end
  end

endmodule

>>> rtl/outlier_rejecting_rms_current_top.sv
// Throughput: one sample per cycle while loading; no sample is taken during the
// per-window pass, which runs one shared 32x32 multiplier over each stored sample,
// then the divider (twice, or once when no sample is kept) and, when samples are
// kept, the square root.
// Reset (rst, synchronous): clears counts, sums and handshakes, restores register defaults.
module outlier_rejecting_rms_current_top #(
  parameter int MAX_SAMPLES = orms_pkg::MAX_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  orms_in_if.sink   samples,
  orms_out_if.source results,
  orms_cfg_if.sink  cfg
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);

  typedef enum logic [22:0] {
    S_LOAD = 23'd1 << 0,  S_NQLO = 23'd1 << 1,  S_NQHI = 23'd1 << 2,
    S_SS   = 23'd1 << 3,  S_VAR  = 23'd1 << 4,  S_ADDR = 23'd1 << 5,
    S_NX   = 23'd1 << 6,  S_DM   = 23'd1 << 7,  S_SQ   = 23'd1 << 8,
    S_V    = 23'd1 << 9,  S_D    = 23'd1 << 10, S_AD   = 23'd1 << 11,
    S_ACC  = 23'd1 << 12, S_DIVK = 23'd1 << 13, S_WAITK = 23'd1 << 14,
    S_WAITR = 23'd1 << 15, S_RAW = 23'd1 << 16, S_DIVR = 23'd1 << 17,
    S_WAITD = 23'd1 << 18, S_CORR = 23'd1 << 19, S_PLO = 23'd1 << 20,
    S_PHI  = 23'd1 << 21, S_FIN  = 23'd1 << 22
  } state_t;

  state_t state;

  logic signed [orms_pkg::OFFSET_W-1:0] offset_voltage;
  logic [31:0]        burden_resistance;
  logic [31:0]        turns_ratio;
  logic signed [31:0] correction_gain;
  logic signed [31:0] correction_offset;

  logic [orms_pkg::SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [orms_pkg::SAMPLE_W-1:0] rdata;

  logic [CW-1:0]                cnt;
  logic [orms_pkg::SUM_W-1:0]   sum;
  logic [orms_pkg::SQ_W-1:0]    sq;
  logic [orms_pkg::NQ_W-1:0]    nq;
  logic [orms_pkg::VAR_W-1:0]   var4;
  logic [CW-1:0]                idx;
  logic [orms_pkg::SAMPLE_W-1:0] xs;
  logic [orms_pkg::DM_W-1:0]    dm;
  logic                         keep;
  logic [orms_pkg::AD_W-1:0]    ad;
  logic [orms_pkg::SUMSQ_W-1:0] sumsq;
  logic [CW-1:0]                kept;
  logic [31:0]                  rms;
  logic [orms_pkg::RAW_W-1:0]   raw;
  logic [orms_pkg::MAG_W-1:0]   mag;
  logic [31:0]                  gabs;
  logic                         neg;
  logic [63:0]                  plo;
  logic [orms_pkg::CURRENT_W-1:0] res;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic                 in_acc;
  logic                 room;
  logic                 out_free;

  logic                 div_start;
  logic [63:0]          div_dividend;
  logic [31:0]          div_divisor;
  orms_pkg::unit_stat_t div_stat;
  logic [63:0]          div_quo;
  logic                 sqrt_start;
  orms_pkg::unit_stat_t sqrt_stat;
  logic [31:0]          sqrt_root;

  logic [63:0]                 nx_diff;
  logic [19:0]                 volt;
  logic signed [21:0]          dsig;
  logic signed [59:0]          diff;
  logic [orms_pkg::PROD_W-1:0] pfull;
  logic [30:0]                 vnum;

  assign samples.ready = state == S_LOAD;
  assign cfg.ready     = 1'b1;
  assign in_acc        = samples.valid && samples.ready;
  assign room          = cnt < CW'(MAX_SAMPLES);
  assign out_free      = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_voltage    <= '0;
      burden_resistance <= orms_pkg::BURDEN_RST;
      turns_ratio       <= orms_pkg::TURNS_RST;
      correction_gain   <= orms_pkg::GAIN_RST;
      correction_offset <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (orms_pkg::cfg_reg_t'(cfg.index))
        orms_pkg::REG_OFFSET_VOLTAGE:    offset_voltage <= cfg.data[orms_pkg::OFFSET_W-1:0];
        orms_pkg::REG_BURDEN_RESISTANCE: burden_resistance <= cfg.data;
        orms_pkg::REG_TURNS_RATIO:       turns_ratio <= cfg.data;
        orms_pkg::REG_CORRECTION_GAIN:   correction_gain <= cfg.data;
        orms_pkg::REG_CORRECTION_OFFSET: correction_offset <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      mem[cnt[AW-1:0]] <= samples.adc_sample;
    end
    rdata <= mem[idx[AW-1:0]];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    vnum  = 31'(xs) * 31'd11 * 31'd32768 + orms_pkg::VOLT_BIAS;
    unique case (state)
      S_NQLO: begin mul_a = 32'(cnt); mul_b = sq[31:0]; end
      S_NQHI: begin mul_a = 32'(cnt); mul_b = 32'(sq[orms_pkg::SQ_W-1:32]); end
      S_SS:   begin mul_a = 32'(sum); mul_b = 32'(sum); end
      S_NX:   begin mul_a = 32'(cnt); mul_b = 32'(rdata); end
      S_SQ:   begin mul_a = 32'(dm); mul_b = 32'(dm); end
      S_V:    begin mul_a = 32'(vnum); mul_b = orms_pkg::RECIP_M; end
      S_AD:   begin mul_a = 32'(ad); mul_b = 32'(ad); end
      S_RAW:  begin mul_a = rms; mul_b = turns_ratio; end
      S_PLO:  begin mul_a = mag[31:0]; mul_b = gabs; end
      S_PHI:  begin mul_a = 32'(mag[46:32]); mul_b = gabs; end
      S_FIN:  begin mul_a = 32'(mag[46:32]); mul_b = gabs; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  assign div_start    = (state == S_DIVK && kept != '0) || state == S_DIVR;
  assign div_dividend = state == S_DIVK ? 64'(sumsq) : prod;
  assign div_divisor  = state == S_DIVK ? 32'(kept)
                      : (burden_resistance != '0 ? burden_resistance : 32'd1);
  assign sqrt_start   = state == S_WAITK && div_stat.done;

  orms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  orms_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (div_quo),
    .stat     (sqrt_stat),
    .root     (sqrt_root)
  );

  assign nx_diff = prod >= 64'(sum) ? prod - 64'(sum) : 64'(sum) - prod;
  assign volt    = prod[orms_pkg::RECIP_SH +: 20];
  assign dsig    = $signed({2'b00, volt}) - 22'(offset_voltage);
  assign diff    = $signed({2'b00, raw}) - 60'(correction_offset);
  assign pfull   = orms_pkg::PROD_W'(plo) + (orms_pkg::PROD_W'(prod) << 32);

  always_comb begin
    if (mag == '0 || gabs == '0) begin
      res = '0;
    end else if (neg) begin
      if (mag >= (orms_pkg::MAG_W'(1) << 47) || pfull >= (orms_pkg::PROD_W'(1) << 47)) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'd0 - 32'((pfull + orms_pkg::PROD_W'(65535)) >> 16);
      end
    end else begin
      if (mag >= (orms_pkg::MAG_W'(1) << 47) || pfull >= (orms_pkg::PROD_W'(1) << 47)) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = pfull[47:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      cnt           <= '0;
      sum           <= '0;
      sq            <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (room) begin
              cnt <= cnt + CW'(1);
              sum <= sum + orms_pkg::SUM_W'(samples.adc_sample);
              sq  <= sq + orms_pkg::SQ_W'(samples.adc_sample) *
                          orms_pkg::SQ_W'(samples.adc_sample);
            end
            if (samples.last_sample) begin
              state <= S_NQLO;
            end
          end
        end
        S_NQLO: state <= S_NQHI;
        S_NQHI: state <= S_SS;
        S_SS:   state <= S_VAR;
        S_VAR:  state <= cnt == '0 ? S_DIVK : S_ADDR;
        S_ADDR: state <= S_NX;
        S_NX:   state <= S_DM;
        S_DM:   state <= S_SQ;
        S_SQ:   state <= S_V;
        S_V:    state <= S_D;
        S_D:    state <= S_AD;
        S_AD:   state <= S_ACC;
        S_ACC:  state <= (idx + CW'(1) == cnt) ? S_DIVK : S_ADDR;
        S_DIVK: state <= kept == '0 ? S_RAW : S_WAITK;
        S_WAITK: begin
          if (div_stat.done) begin
            state <= S_WAITR;
          end
        end
        S_WAITR: begin
          if (sqrt_stat.done) begin
            state <= S_RAW;
          end
        end
        S_RAW:  state <= S_DIVR;
        S_DIVR: state <= S_WAITD;
        S_WAITD: begin
          if (div_stat.done) begin
            state <= S_CORR;
          end
        end
        S_CORR: state <= S_PLO;
        S_PLO:  state <= S_PHI;
        S_PHI:  state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            results.valid <= 1'b1;
            cnt           <= '0;
            sum           <= '0;
            sq            <= '0;
            state         <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_NQHI: nq <= orms_pkg::NQ_W'(prod);
      S_SS:   nq <= nq + (orms_pkg::NQ_W'(prod) << 32);
      S_VAR: begin
        var4  <= nq > orms_pkg::NQ_W'(prod)
               ? orms_pkg::VAR_W'(nq - orms_pkg::NQ_W'(prod)) << 2 : '0;
        idx   <= '0;
        sumsq <= '0;
        kept  <= '0;
        rms   <= '0;
      end
      S_NX:   xs <= rdata;
      S_DM:   dm <= orms_pkg::DM_W'(nx_diff);
      S_V:    keep <= prod < 64'(var4);
      S_D:    ad <= orms_pkg::AD_W'(dsig < 0 ? -dsig : dsig);
      S_ACC: begin
        if (keep) begin
          sumsq <= sumsq + orms_pkg::SUMSQ_W'(prod);
          kept  <= kept + CW'(1);
        end
        idx <= idx + CW'(1);
      end
      S_WAITR: begin
        if (sqrt_stat.done) begin
          rms <= sqrt_root;
        end
      end
      S_WAITD: begin
        if (div_stat.done) begin
          raw <= orms_pkg::RAW_W'(div_quo);
        end
      end
      S_CORR: begin
        mag  <= orms_pkg::MAG_W'(diff < 0 ? -diff : diff);
        gabs <= correction_gain < 0 ? 32'd0 - correction_gain : correction_gain;
        neg  <= (diff < 0) != (correction_gain < 0);
      end
      S_PHI:  plo <= prod;
      S_FIN: begin
        if (out_free) begin
          results.current_value <= res;
          results.kept_count    <= orms_pkg::KEPT_W'(kept);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/orms_chk.sv
`include "outlier_rejecting_rms_current_top_defines.svh"

module orms_chk #(
  parameter int MAX_SAMPLES = orms_pkg::MAX_SAMPLES_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_last,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [orms_pkg::CURRENT_W-1:0] out_current,
  input logic [orms_pkg::KEPT_W-1:0]    out_kept,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  `ORMS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_current), "result dropped or changed while stalled")
  `ORMS_ASSERT_NEXT(a_close_busy, clk, rst, in_valid && in_ready && in_last, !in_ready, "sample taken right after window close")
  `ORMS_ASSERT_NOW(a_kept_range, clk, rst, out_valid, 32'(out_kept) <= 32'(MAX_SAMPLES), "kept count above window size")
  `ORMS_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind outlier_rejecting_rms_current_top orms_chk #(.MAX_SAMPLES(MAX_SAMPLES)) u_orms_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .in_last     (samples.last_sample),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_current (results.current_value),
  .out_kept    (results.kept_count),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready)
);

>>> dv/orms_checker.sv
`timescale 1ns / 100ps

module orms_checker (
  input  logic  clk,
  input  logic  rst,
  orms_in_if    samples,
  orms_out_if   results,
  orms_cfg_if   cfg,
  output int    errors,
  output int    pending
);

  localparam int WINDOW_MAX = orms_pkg::MAX_SAMPLES_DEF;

  typedef struct {
    logic signed [31:0] current_value;
    logic [10:0]        kept_count;
  } meas_t;

  logic [11:0]        window[WINDOW_MAX];
  int                 win_len;
  logic signed [18:0] offset_v;
  logic [31:0]        burden;
  logic [31:0]        turns;
  logic signed [31:0] gain;
  logic signed [31:0] intercept;
  meas_t              expected_meas[$];

  assign pending = expected_meas.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] apply_correction(longint diff, longint g);
    logic [63:0] lim;
    logic        neg;
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] p;
    lim = 64'd1 << 47;
    neg = (diff < 0) != (g < 0);
    m = diff < 0 ? -diff : diff;
    a = g < 0 ? -g : g;
    if (m == 0 || a == 0) return 32'd0;
    if (m > lim / a) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    p = m * a;
    if (!neg) begin
      if (p >= lim) return 32'h7FFF_FFFF;
      return p[47:16];
    end
    p = (p + 64'd65535) >> 16;
    return -p[31:0];
  endfunction

  function automatic meas_t predict_current();
    meas_t       r;
    logic [63:0] n;
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] var4;
    logic [63:0] dm;
    logic [63:0] sumsq;
    logic [63:0] rms;
    logic [63:0] raw;
    logic [63:0] ad;
    longint      d;
    int          k;
    n = win_len;
    s = 0;
    q = 0;
    sumsq = 0;
    rms = 0;
    k = 0;
    for (int i = 0; i < win_len; i++) begin
      s += window[i];
      q += window[i] * window[i];
    end
    var4 = n * q > s * s ? 4 * (n * q - s * s) : 64'd0;
    for (int i = 0; i < win_len; i++) begin
      dm = n * window[i];
      dm = dm >= s ? dm - s : s - dm;
      if (dm * dm < var4) begin
        d = longint'((64'(window[i]) * 360448 + 3412) / 6825) - longint'(offset_v);
        ad = d < 0 ? -d : d;
        sumsq += ad * ad;
        k++;
      end
    end
    if (k != 0) rms = int_sqrt(sumsq / k);
    raw = (rms * turns) / (burden != 0 ? 64'(burden) : 64'd1);
    r.current_value = apply_correction(longint'(raw) - longint'(intercept), longint'(gain));
    r.kept_count = k[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      win_len = 0;
      offset_v = 0;
      burden = orms_pkg::BURDEN_RST;
      turns = orms_pkg::TURNS_RST;
      gain = orms_pkg::GAIN_RST;
      intercept = 0;
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (orms_pkg::cfg_reg_t'(cfg.index))
          orms_pkg::REG_OFFSET_VOLTAGE:    offset_v = cfg.data[18:0];
          orms_pkg::REG_BURDEN_RESISTANCE: burden = cfg.data;
          orms_pkg::REG_TURNS_RATIO:       turns = cfg.data;
          orms_pkg::REG_CORRECTION_GAIN:   gain = cfg.data;
          orms_pkg::REG_CORRECTION_OFFSET: intercept = cfg.data;
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        if (win_len < WINDOW_MAX) begin
          window[win_len] = samples.adc_sample;
          win_len = win_len + 1;
        end
        if (samples.last_sample) begin
          expected_meas.push_back(predict_current());
          win_len = 0;
        end
      end
      if (results.valid && results.ready) begin
        if (expected_meas.size() == 0) begin
          report_mismatch("unexpected result", results.current_value, 0);
        end else begin
          if (results.current_value !== expected_meas[0].current_value)
            report_mismatch("current_value", results.current_value,
                            expected_meas[0].current_value);
          if (results.kept_count !== expected_meas[0].kept_count)
            report_mismatch("kept_count", results.kept_count, expected_meas[0].kept_count);
          void'(expected_meas.pop_front());
        end
      end
    end
  end
endmodule

>>> dv/tb_outlier_rejecting_rms_current_top.sv
`timescale 1ns / 100ps

module tb_outlier_rejecting_rms_current_top;

  localparam int STALL_LIMIT = 200000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   idle_cycles;

  orms_in_if  samples();
  orms_out_if results();
  orms_cfg_if cfg();

  outlier_rejecting_rms_current_top u_top (
    .clk(clk), .rst(rst), .samples(samples), .results(results), .cfg(cfg)
  );

  orms_checker u_checker (
    .clk(clk), .rst(rst), .samples(samples), .results(results), .cfg(cfg),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int wait_cycles;
    results.ready = 0;
    @(negedge clk);
    while (!rst) @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_cycles != 0) begin
        results.ready <= 0;
        repeat (wait_cycles) @(negedge clk);
      end
      results.ready <= 1;
      @(posedge clk);
      while (!results.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_sample(logic [11:0] x, logic last, bit gaps);
    int wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 11) : 0;
    if (wait_cycles != 0) begin
      samples.valid <= 0;
      repeat (wait_cycles) @(negedge clk);
    end
    samples.valid <= 1;
    samples.adc_sample <= x;
    samples.last_sample <= last;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    samples.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(orms_pkg::cfg_reg_t idx, logic [31:0] value);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_window(int len, int style, bit gaps);
    logic [11:0] center;
    logic [11:0] x;
    center = $urandom_range(0, 4095);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: x = $urandom_range(0, 4095);
        1: x = 12'(center + $urandom_range(0, 40) - 20);
        default: x = ($urandom_range(0, 9) == 0) ? 12'($urandom) : center;
      endcase
      send_sample(x, i == len - 1, gaps);
    end
  endtask

  task automatic program_random();
    write_reg(orms_pkg::REG_OFFSET_VOLTAGE, 32'($urandom_range(0, 524287)));
    write_reg(orms_pkg::REG_BURDEN_RESISTANCE,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(16384, 600000));
    write_reg(orms_pkg::REG_TURNS_RATIO,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(65536, 6553600));
    write_reg(orms_pkg::REG_CORRECTION_GAIN,
              $urandom_range(0, 3) == 0 ? $urandom : 32'(int'($urandom_range(0, 262144)) - 65536));
    write_reg(orms_pkg::REG_CORRECTION_OFFSET,
              $urandom_range(0, 3) == 0 ? $urandom : 32'(int'($urandom_range(0, 2000000)) - 1000000));
  endtask

  initial begin
    int sent;
    int len;
    samples.valid = 0;
    samples.adc_sample = 0;
    samples.last_sample = 0;
    cfg.valid = 0;
    cfg.index = orms_pkg::REG_OFFSET_VOLTAGE;
    cfg.data = 0;
    rst = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_sample(12'd0, 1, 0);
    send_sample(12'd4095, 0, 0);
    send_sample(12'd0, 1, 0);
    for (int i = 0; i < 4; i++) send_sample(12'd2048, i == 3, 0);
    for (int i = 0; i < 10; i++) send_sample(i == 5 ? 12'd4095 : 12'd100, i == 9, 0);
    send_sample(12'hAAA, 0, 0);
    send_sample(12'h555, 0, 0);
    send_sample(12'hFFF, 0, 0);
    send_sample(12'h001, 1, 0);
    drain_results();

    write_reg(orms_pkg::REG_OFFSET_VOLTAGE, 32'h0003_FFFF);
    write_reg(orms_pkg::REG_BURDEN_RESISTANCE, 32'd1);
    write_reg(orms_pkg::REG_TURNS_RATIO, 32'hFFFF_FFFF);
    write_reg(orms_pkg::REG_CORRECTION_GAIN, 32'h7FFF_FFFF);
    write_reg(orms_pkg::REG_CORRECTION_OFFSET, 32'h8000_0000);
    send_window(8, 0, 0);
    drain_results();
    write_reg(orms_pkg::REG_OFFSET_VOLTAGE, 32'h0004_0000);
    write_reg(orms_pkg::REG_BURDEN_RESISTANCE, 32'hFFFF_FFFF);
    write_reg(orms_pkg::REG_TURNS_RATIO, 32'd1);
    write_reg(orms_pkg::REG_CORRECTION_GAIN, 32'h8000_0000);
    write_reg(orms_pkg::REG_CORRECTION_OFFSET, 32'h7FFF_FFFF);
    send_window(8, 0, 0);
    drain_results();
    write_reg(orms_pkg::REG_BURDEN_RESISTANCE, 32'd0);
    send_window(6, 1, 0);
    drain_results();

    write_reg(orms_pkg::REG_OFFSET_VOLTAGE, 32'd0);
    write_reg(orms_pkg::REG_BURDEN_RESISTANCE, 32'd65536);
    write_reg(orms_pkg::REG_TURNS_RATIO, 32'd65536);
    write_reg(orms_pkg::REG_CORRECTION_GAIN, 32'd65536);
    write_reg(orms_pkg::REG_CORRECTION_OFFSET, 32'd0);

    sent = 0;
    while (sent < 360) begin
      if ($urandom_range(0, 5) == 0) begin
        drain_results();
        program_random();
      end
      len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 16);
      send_window(len, $urandom_range(0, 2), $urandom_range(0, 2) != 0);
      sent += len;
    end
    drain_results();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/orms_pkg.sv
rtl/orms_if.sv
rtl/orms_div.sv
rtl/orms_sqrt.sv
rtl/outlier_rejecting_rms_current_top.sv
rtl/orms_chk.sv
dv/orms_checker.sv
dv/tb_outlier_rejecting_rms_current_top.sv
